// File: hw/rtl/fet_pkg.sv
package fet_pkg;

    // Configuration register
    localparam int unsigned       LIMIT_W     = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Command codes
    localparam logic [1:0] CMD_NOTIFY = 2'd0;
    localparam logic [1:0] CMD_CLOSE  = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_NOTIFIED = 2'd0;
    localparam logic [1:0] KIND_EVICTED  = 2'd1;
    localparam logic [1:0] KIND_CLOSED   = 2'd2;
    localparam logic [1:0] KIND_QUERY    = 2'd3;

    // Fixed values
    localparam logic [30:0] DEFAULT_TIMEOUT = 31'd5000;
    localparam logic [31:0] EVICT_REASON    = 32'd4;

    // One result beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] id;
        logic [31:0] reason;
        logic [30:0] timeout;
        logic        found;
        logic        last;
    } t_result;

endpackage

// File: hw/rtl/fet_ifs.sv
interface fet_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [31:0]        item_id;
    logic [31:0]        close_reason;
    logic signed [31:0] timeout_req;

    modport source (
        output valid, command, item_id, close_reason, timeout_req,
        input  ready
    );
    modport sink (
        input  valid, command, item_id, close_reason, timeout_req,
        output ready
    );
endinterface

interface fet_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] result_id;
    logic [31:0] result_reason;
    logic [30:0] effective_timeout;
    logic        found;
    logic        last;

    modport source (
        output valid, result_kind, result_id, result_reason, effective_timeout,
               found, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, result_id, result_reason, effective_timeout,
               found, last,
        output ready
    );
endinterface

// File: hw/rtl/fet_result_reg.sv
module fet_result_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  fet_pkg::t_result i_beat,
    output logic             o_can_load,
    fet_res_if.source        o_res
);
    import fet_pkg::*;

    logic    r_valid;
    t_result r_beat;

    // Accept a new beat when empty or when the held beat leaves this cycle
    assign o_can_load = !r_valid || o_res.ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // Hold the payload
    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_beat <= i_beat;
        end
    end

    assign o_res.valid             = r_valid;
    assign o_res.result_kind       = r_beat.kind;
    assign o_res.result_id         = r_beat.id;
    assign o_res.result_reason     = r_beat.reason;
    assign o_res.effective_timeout = r_beat.timeout;
    assign o_res.found             = r_beat.found;
    assign o_res.last              = r_beat.last;

endmodule

// File: hw/rtl/fifo_evicting_id_table_unit.sv
// Table of active 32-bit ids kept oldest first in a single-port-read RAM, with
// a wrapping id allocator that skips ids in use. One command is worked at a
// time; the command port is ready only while the engine is idle, and a result
// beat waits in an output register so the next command can enter meanwhile.
// Every id lookup walks the RAM one entry per cycle, a removal reads each later
// entry and writes it back one place down, and the append and result steps follow.
// An allocating notify repeats the lookup once for each candidate found in use,
// at most CAPACITY + 1 lookups. A notify of a new id while the count is at the
// limit reports the evicted id in one beat (last low) ahead of the notify beat.
module fifo_evicting_id_table_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [fet_pkg::LIMIT_W-1:0] i_cfg_data,
    fet_cmd_if.sink                     i_cmd,
    fet_res_if.source                   o_res
);
    import fet_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_EVICT  = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_APPEND = 3'd4;
    localparam logic [2:0] ST_FINAL  = 3'd5;

    // Control state
    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [31:0]        r_cand, n_cand;
    logic [LIMIT_W-1:0] r_limit;
    logic               r_rd_valid, n_rd_valid;

    // Working registers of the current command
    logic [1:0]    r_cmd, n_cmd;
    logic [31:0]   r_target, n_target;
    logic [31:0]   r_reason, n_reason;
    logic [30:0]   r_tmo, n_tmo;
    logic          r_alloc, n_alloc;
    logic          r_found, n_found;
    logic [CW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_rd_idx, n_rd_idx;

    // Order memory
    logic [31:0]   r_order_mem [CAPACITY];
    logic [31:0]   r_rd_data;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;

    // Result path
    logic    res_load;
    logic    res_can_load;
    t_result res_beat;

    logic          hit;
    logic          scan_more;
    logic [CW-1:0] lim;
    logic          evict_needed;
    logic [31:0]   cand_adv;

    // Clamp the limit to the table size
    assign lim = ({27'd0, r_limit} > 32'(CAPACITY)) ? CW'(CAPACITY) : CW'(r_limit);
    assign evict_needed = (lim != '0) && (r_count >= lim) && (r_count != '0);

    assign hit       = r_rd_valid && (r_rd_data == r_target);
    assign scan_more = r_idx < r_count;
    assign cand_adv  = (r_cand == 32'hFFFF_FFFF) ? 32'd1 : r_cand + 32'd1;

    assign i_cmd.ready = (r_state == ST_IDLE);

    // Sequence one command
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_cand     = r_cand;
        n_rd_valid = r_rd_valid;
        n_cmd      = r_cmd;
        n_target   = r_target;
        n_reason   = r_reason;
        n_tmo      = r_tmo;
        n_alloc    = r_alloc;
        n_found    = r_found;
        n_idx      = r_idx;
        n_rd_idx   = r_rd_idx;
        mem_re     = 1'b0;
        mem_raddr  = r_idx[AW-1:0];
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = r_target;
        res_load   = 1'b0;
        res_beat   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd      = i_cmd.command;
                    n_reason   = i_cmd.close_reason;
                    n_tmo      = i_cmd.timeout_req[31] ? DEFAULT_TIMEOUT
                                                       : i_cmd.timeout_req[30:0];
                    n_idx      = '0;
                    n_rd_valid = 1'b0;
                    if (i_cmd.command != CMD_UNUSED) begin
                        n_state = ST_SCAN;
                    end
                    if (i_cmd.command == CMD_NOTIFY && i_cmd.item_id == 32'd0) begin
                        n_target = r_cand;
                        n_cand   = cand_adv;
                        n_alloc  = 1'b1;
                    end else begin
                        n_target = i_cmd.item_id;
                        n_alloc  = 1'b0;
                    end
                end
            end

            ST_SCAN: begin
                if (hit && r_alloc) begin
                    // candidate in use: take the next one and look again
                    n_target   = r_cand;
                    n_cand     = cand_adv;
                    n_idx      = '0;
                    n_rd_valid = 1'b0;
                end else if (hit) begin
                    n_found    = 1'b1;
                    n_rd_valid = 1'b0;
                    if (r_cmd == CMD_QUERY) begin
                        n_state = ST_FINAL;
                    end else begin
                        n_idx   = CW'(r_rd_idx) + CW'(1);
                        n_state = ST_SHIFT;
                    end
                end else if (!scan_more && !r_rd_valid) begin
                    n_found = 1'b0;
                    if (r_cmd == CMD_NOTIFY) begin
                        if (evict_needed) begin
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            n_state   = ST_EVICT;
                        end else begin
                            n_state = ST_APPEND;
                        end
                    end else begin
                        n_state = ST_FINAL;
                    end
                end else if (scan_more) begin
                    mem_re     = 1'b1;
                    n_idx      = r_idx + CW'(1);
                    n_rd_valid = 1'b1;
                    n_rd_idx   = r_idx[AW-1:0];
                end else begin
                    n_rd_valid = 1'b0;
                end
            end

            ST_EVICT: begin
                // report the oldest id, then close the gap at the head
                if (res_can_load) begin
                    res_load        = 1'b1;
                    res_beat.kind   = KIND_EVICTED;
                    res_beat.id     = r_rd_data;
                    res_beat.reason = EVICT_REASON;
                    n_idx           = CW'(1);
                    n_rd_valid      = 1'b0;
                    n_state         = ST_SHIFT;
                end
            end

            ST_SHIFT: begin
                // move each later entry down by one
                if (r_rd_valid) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(r_rd_idx - AW'(1));
                    mem_wdata = r_rd_data;
                end
                if (scan_more) begin
                    mem_re     = 1'b1;
                    n_idx      = r_idx + CW'(1);
                    n_rd_valid = 1'b1;
                    n_rd_idx   = r_idx[AW-1:0];
                end else begin
                    n_rd_valid = 1'b0;
                    if (!r_rd_valid) begin
                        n_count = r_count - CW'(1);
                        n_state = (r_cmd == CMD_NOTIFY) ? ST_APPEND : ST_FINAL;
                    end
                end
            end

            ST_APPEND: begin
                if (lim != '0 && r_count < CW'(CAPACITY)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_count[AW-1:0];
                    mem_wdata = r_target;
                    n_count   = r_count + CW'(1);
                end
                n_state = ST_FINAL;
            end

            ST_FINAL: begin
                if (res_can_load) begin
                    res_load      = 1'b1;
                    res_beat.id   = r_target;
                    res_beat.last = 1'b1;
                    unique case (r_cmd)
                        CMD_NOTIFY: begin
                            res_beat.kind    = KIND_NOTIFIED;
                            res_beat.timeout = r_tmo;
                        end
                        CMD_CLOSE: begin
                            res_beat.kind   = KIND_CLOSED;
                            res_beat.reason = r_found ? r_reason : 32'd0;
                            res_beat.found  = r_found;
                        end
                        default: begin
                            res_beat.kind  = KIND_QUERY;
                            res_beat.found = r_found;
                        end
                    endcase
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_cand     <= 32'd1;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_cand     <= n_cand;
            r_rd_valid <= n_rd_valid;
        end
    end

    // Hold the limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_target <= n_target;
        r_reason <= n_reason;
        r_tmo    <= n_tmo;
        r_alloc  <= n_alloc;
        r_found  <= n_found;
        r_idx    <= n_idx;
        r_rd_idx <= n_rd_idx;
    end

    // Order memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_order_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_order_mem[mem_raddr];
        end
    end

    fet_result_reg u_result_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_load),
        .i_beat     (res_beat),
        .o_can_load (res_can_load),
        .o_res      (o_res)
    );

endmodule

// File: test/tb.sv
module tb;
    import fet_pkg::*;

    localparam int TBL_DEPTH     = 16;
    localparam int SETTLE_CYCLES = 400;   // worst allocating notify walks ~17 lookups
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 900;
    localparam int REPORT_MAX    = 10;

    typedef enum logic [1:0] {STEP_CMD, STEP_DRAIN, STEP_CFG} step_kind_e;

    typedef struct {
        step_kind_e         kind;
        logic [1:0]         command;
        logic [31:0]        item_id;
        logic [31:0]        reason;
        logic [31:0]        tmo;
        logic [LIMIT_W-1:0] limit;
    } plan_step_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_data;

    fet_cmd_if cmd_bus ();
    fet_res_if res_bus ();

    fifo_evicting_id_table_unit #(
        .CAPACITY (TBL_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_bus),
        .o_res      (res_bus)
    );

    // Mirror of the id table, allocator and limit register
    logic [31:0]        mirror_ids [TBL_DEPTH];
    int unsigned        mirror_count;
    logic [31:0]        alloc_next;
    logic [LIMIT_W-1:0] mirror_limit;

    plan_step_t  cmd_plan [$];
    t_result     results_due [$];
    int unsigned fail_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int slot_of(logic [31:0] id);
        for (int i = 0; i < mirror_count; i++)
            if (mirror_ids[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void drop_slot(int unsigned pos);
        for (int unsigned i = pos; i + 1 < mirror_count; i++)
            mirror_ids[i] = mirror_ids[i + 1];
        mirror_count--;
    endfunction

    // Take the counter value, advance with wrap past zero, skip ids in use
    function automatic logic [31:0] draw_free_id();
        logic [31:0] cand;
        do begin
            cand       = alloc_next;
            alloc_next = alloc_next + 32'd1;
            if (alloc_next == 32'd0)
                alloc_next = 32'd1;
        end while (cand == 32'd0 || slot_of(cand) >= 0);
        return cand;
    endfunction

    function automatic void note_due(logic [1:0] kind, logic [31:0] id, logic [31:0] reason,
                                     logic [30:0] tmo, logic found, logic last);
        t_result r;
        r.kind    = kind;
        r.id      = id;
        r.reason  = reason;
        r.timeout = tmo;
        r.found   = found;
        r.last    = last;
        results_due.insert(results_due.size(), r);
    endfunction

    // Update the mirror for one accepted command and queue the beats it causes
    function automatic void apply_command(plan_step_t s);
        logic [31:0] eff;
        logic [30:0] tmo;
        int          pos;
        int unsigned lim;
        lim = (mirror_limit > TBL_DEPTH) ? TBL_DEPTH : mirror_limit;
        case (s.command)
            CMD_NOTIFY: begin
                eff = (s.item_id != 32'd0) ? s.item_id : draw_free_id();
                tmo = s.tmo[31] ? DEFAULT_TIMEOUT : s.tmo[30:0];
                pos = slot_of(eff);
                if (pos >= 0) begin
                    drop_slot(pos);
                end else if (lim != 0 && mirror_count >= lim && mirror_count > 0) begin
                    note_due(KIND_EVICTED, mirror_ids[0], EVICT_REASON, '0, 1'b0, 1'b0);
                    drop_slot(0);
                end
                if (lim != 0 && mirror_count < TBL_DEPTH) begin
                    mirror_ids[mirror_count] = eff;
                    mirror_count++;
                end
                note_due(KIND_NOTIFIED, eff, '0, tmo, 1'b0, 1'b1);
            end
            CMD_CLOSE: begin
                pos = slot_of(s.item_id);
                if (pos >= 0) begin
                    drop_slot(pos);
                    note_due(KIND_CLOSED, s.item_id, s.reason, '0, 1'b1, 1'b1);
                end else begin
                    note_due(KIND_CLOSED, s.item_id, '0, '0, 1'b0, 1'b1);
                end
            end
            CMD_QUERY: begin
                pos = slot_of(s.item_id);
                note_due(KIND_QUERY, s.item_id, '0, '0, pos >= 0, 1'b1);
            end
            default: ;  // unused command: no beat, no state change
        endcase
    endfunction

    // Command driver: holds each beat until taken, honors drain and config steps
    plan_step_t  in_flight;
    plan_step_t  head;
    int unsigned gap_left;
    int unsigned settle_cnt;
    bit          send_burst;
    logic        next_valid;
    logic        next_we;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
            cfg_we        <= 1'b0;
            gap_left   = 0;
            settle_cnt = 0;
            send_burst = 1'b0;
        end else begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                apply_command(in_flight);
                if ($urandom_range(0, 63) == 0)
                    send_burst = !send_burst;
                gap_left = send_burst ? 0 : $urandom_range(0, 7);
            end
            if (!cmd_bus.valid || cmd_bus.ready) begin
                next_valid = 1'b0;
                next_we    = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_plan.size() > 0) begin
                    head = cmd_plan[0];
                    case (head.kind)
                        STEP_CMD: begin
                            in_flight = head;
                            cmd_plan.delete(0);
                            next_valid = 1'b1;
                            cmd_bus.command      <= head.command;
                            cmd_bus.item_id      <= head.item_id;
                            cmd_bus.close_reason <= head.reason;
                            cmd_bus.timeout_req  <= head.tmo;
                        end
                        STEP_DRAIN: begin
                            if (results_due.size() == 0)
                                cmd_plan.delete(0);
                        end
                        default: begin
                            // write the limit only once the engine has gone quiet
                            if (results_due.size() != 0) begin
                                settle_cnt = 0;
                            end else if (settle_cnt < SETTLE_CYCLES) begin
                                settle_cnt++;
                            end else begin
                                settle_cnt   = 0;
                                next_we      = 1'b1;
                                cfg_data    <= head.limit;
                                mirror_limit = head.limit;
                                cmd_plan.delete(0);
                            end
                        end
                    endcase
                end
                cmd_bus.valid <= next_valid;
                cfg_we        <= next_we;
            end
        end
    end

    // Result monitor: random backpressure, check each beat against the oldest due
    int unsigned stall_left;
    bit          recv_burst;
    t_result     got;
    t_result     want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            stall_left = 0;
            recv_burst = 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                got.kind    = res_bus.result_kind;
                got.id      = res_bus.result_id;
                got.reason  = res_bus.result_reason;
                got.timeout = res_bus.effective_timeout;
                got.found   = res_bus.found;
                got.last    = res_bus.last;
                if (results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected beat: kind=%0d id=%h reason=%h tmo=%0d %s%b %s%b",
                                 got.kind, got.id, got.reason, got.timeout,
                                 "found=", got.found, "last=", got.last);
                end else begin
                    want = results_due[0];
                    results_due.delete(0);
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX) begin
                            $write("beat mismatch: want kind=%0d id=%h reason=%h tmo=%0d ",
                                   want.kind, want.id, want.reason, want.timeout);
                            $write("found=%b last=%b, ", want.found, want.last);
                            $write("got kind=%0d id=%h reason=%h tmo=%0d ",
                                   got.kind, got.id, got.reason, got.timeout);
                            $display("found=%b last=%b", got.found, got.last);
                        end
                    end
                end
                if ($urandom_range(0, 63) == 0)
                    recv_burst = !recv_burst;
                stall_left = recv_burst ? 0 : $urandom_range(0, 7);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            res_bus.ready <= (stall_left == 0);
        end
    end

    // Watchdog: abort when neither side has moved a beat for too long
    int unsigned idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_bus.valid && cmd_bus.ready) ||
            (res_bus.valid && res_bus.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic push_cmd(logic [1:0] command, logic [31:0] id, logic [31:0] reason,
                            logic [31:0] tmo);
        plan_step_t s;
        s.kind    = STEP_CMD;
        s.command = command;
        s.item_id = id;
        s.reason  = reason;
        s.tmo     = tmo;
        s.limit   = '0;
        cmd_plan.insert(cmd_plan.size(), s);
    endtask

    task automatic push_ctl(step_kind_e kind, logic [LIMIT_W-1:0] limit);
        plan_step_t s;
        s.kind    = kind;
        s.command = CMD_NOTIFY;
        s.item_id = '0;
        s.reason  = '0;
        s.tmo     = '0;
        s.limit   = limit;
        cmd_plan.insert(cmd_plan.size(), s);
    endtask

    // Mostly a small pool so ids collide with the table and the allocator
    function automatic logic [31:0] pick_id();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 40);
        else if (r < 80)
            return $urandom_range(41, 200);
        else if (r < 92)
            return $urandom;
        else if (r < 97)
            return 32'hFFFF_FFFF - $urandom_range(0, 3);
        return 32'd0;
    endfunction

    function automatic logic [31:0] pick_timeout();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3, 4: return $urandom;
            5, 6:          return $urandom_range(0, 10000);
            7:             return 32'hFFFF_FFFF;
            8:             return 32'h7FFF_FFFF;
            default:       return 32'h8000_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_reason();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        else if (r == 1)
            return EVICT_REASON;
        return $urandom;
    endfunction

    int unsigned        counted;
    int unsigned        phase_no;
    int unsigned        phase_len;
    int unsigned        r;
    logic [LIMIT_W-1:0] lim;
    logic [31:0]        req_id;

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_data             = '0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.command      = CMD_NOTIFY;
        cmd_bus.item_id      = '0;
        cmd_bus.close_reason = '0;
        cmd_bus.timeout_req  = '0;
        res_bus.ready        = 1'b0;
        fail_count           = 0;
        idle_cycles          = 0;

        for (int i = 0; i < TBL_DEPTH; i++)
            mirror_ids[i] = '0;
        mirror_count = 0;
        alloc_next   = 32'd1;
        mirror_limit = LIMIT_RESET;

        // Directed: allocation, default timeout, extremes, move to back, skip in use
        push_cmd(CMD_NOTIFY, 32'd0, 32'd0, 32'd100);
        push_cmd(CMD_NOTIFY, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(CMD_NOTIFY, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF);
        push_cmd(CMD_NOTIFY, 32'd3, 32'd0, 32'h8000_0000);
        push_cmd(CMD_NOTIFY, 32'd0, 32'd0, 32'd0);
        push_cmd(CMD_NOTIFY, 32'd1, 32'd0, 32'd7);
        push_cmd(CMD_QUERY, 32'd1, 32'd0, 32'd0);
        push_cmd(CMD_QUERY, 32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(CMD_CLOSE, 32'd2, 32'hFFFF_FFFF, 32'd0);
        push_cmd(CMD_CLOSE, 32'd2, 32'h5A5A_5A5A, 32'd0);
        push_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(CMD_QUERY, 32'd0, 32'd0, 32'd0);
        push_ctl(STEP_DRAIN, '0);
        // Limit lowered under the count: one eviction per new id
        push_ctl(STEP_CFG, 5'd2);
        push_cmd(CMD_NOTIFY, 32'd10, 32'd0, 32'd1);
        push_cmd(CMD_NOTIFY, 32'd3, 32'd0, 32'd2);
        push_cmd(CMD_NOTIFY, 32'd0, 32'd0, 32'd3);
        // Tracking off while ids remain active
        push_ctl(STEP_CFG, 5'd0);
        push_cmd(CMD_QUERY, 32'd1, 32'd0, 32'd0);
        push_cmd(CMD_NOTIFY, 32'd1, 32'd0, 32'd4);
        push_cmd(CMD_NOTIFY, 32'd0, 32'd0, 32'd5);
        push_cmd(CMD_QUERY, 32'd6, 32'd0, 32'd0);
        push_cmd(CMD_CLOSE, 32'd10, 32'h8000_0001, 32'd0);
        push_ctl(STEP_CFG, 5'd31);
        push_cmd(CMD_NOTIFY, 32'h8000_0000, 32'd0, 32'h8000_0000);

        // Random phases, each under its own limit, extremes first
        counted  = 0;
        phase_no = 0;
        while (counted < RANDOM_ITEMS) begin
            case (phase_no)
                0:       lim = 5'd16;
                1:       lim = 5'd1;
                2:       lim = 5'd31;
                3:       lim = 5'd0;
                4:       lim = 5'd17;
                default: lim = ($urandom_range(0, 3) == 0) ? 5'd16 : 5'($urandom_range(0, 31));
            endcase
            phase_no++;
            push_ctl(STEP_CFG, lim);
            phase_len = $urandom_range(60, 140);
            for (int k = 0; k < phase_len && counted < RANDOM_ITEMS; k++) begin
                if ($urandom_range(0, 39) == 0)
                    push_ctl(STEP_DRAIN, '0);
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    req_id = ($urandom_range(0, 5) == 0) ? 32'd0 : pick_id();
                    push_cmd(CMD_NOTIFY, req_id, $urandom, pick_timeout());
                    counted++;
                end else if (r < 70) begin
                    push_cmd(CMD_CLOSE, pick_id(), pick_reason(), $urandom);
                    counted++;
                end else if (r < 95) begin
                    push_cmd(CMD_QUERY, pick_id(), $urandom, $urandom);
                    counted++;
                end else begin
                    push_cmd(CMD_UNUSED, pick_id(), $urandom, $urandom);
                end
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain everything, then give the engine time to finish any ignored command
        while (cmd_plan.size() != 0 || cmd_bus.valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
